// ===== rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types, character codes, parser phases and event codes for the
// resp stream decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // defaults for top level parameters
  localparam int MAX_DEPTH_DEF    = 8;
  localparam int LENGTH_WIDTH_DEF = 32;

  // nesting level width (fixed by the nesting_depth field)
  localparam int DEPTH_W = 4;

  // character codes
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // signed 64-bit limits split as quotient and remainder by ten
  localparam logic [63:0] INT_DIV     = 64'd922337203685477580;
  localparam logic [3:0]  INT_MOD_POS = 4'd7;
  localparam logic [3:0]  INT_MOD_NEG = 4'd8;

  // parser phases
  localparam logic [3:0] PH_TYPE      = 4'd0;
  localparam logic [3:0] PH_LINE      = 4'd1;
  localparam logic [3:0] PH_LINE_LF   = 4'd2;
  localparam logic [3:0] PH_NUM_FIRST = 4'd3;
  localparam logic [3:0] PH_NUM_SIGN  = 4'd4;
  localparam logic [3:0] PH_NUM       = 4'd5;
  localparam logic [3:0] PH_NUM_LF    = 4'd6;
  localparam logic [3:0] PH_BULK      = 4'd7;
  localparam logic [3:0] PH_BULK_CR   = 4'd8;
  localparam logic [3:0] PH_BULK_LF   = 4'd9;
  localparam logic [3:0] PH_ERR       = 4'd10;

  // value types
  localparam logic [2:0] TY_SIMPLE = 3'd0;
  localparam logic [2:0] TY_ERROR  = 3'd1;
  localparam logic [2:0] TY_INT    = 3'd2;
  localparam logic [2:0] TY_BULK   = 3'd3;
  localparam logic [2:0] TY_ARRAY  = 3'd4;

  // event codes
  localparam logic [3:0] EV_SIMPLE_BYTE = 4'd0;
  localparam logic [3:0] EV_SIMPLE_END  = 4'd1;
  localparam logic [3:0] EV_ERROR_BYTE  = 4'd2;
  localparam logic [3:0] EV_ERROR_END   = 4'd3;
  localparam logic [3:0] EV_INTEGER     = 4'd4;
  localparam logic [3:0] EV_BULK_HDR    = 4'd5;
  localparam logic [3:0] EV_NULL_BULK   = 4'd6;
  localparam logic [3:0] EV_BULK_BYTE   = 4'd7;
  localparam logic [3:0] EV_BULK_END    = 4'd8;
  localparam logic [3:0] EV_ARRAY_HDR   = 4'd9;
  localparam logic [3:0] EV_NULL_ARRAY  = 4'd10;
  localparam logic [3:0] EV_PROTO_ERR   = 4'd11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } rsd_in_t;

  typedef struct packed {
    logic [3:0]         event_res;
    logic signed [63:0] value;
    logic [7:0]         payload_byte;
    logic [DEPTH_W-1:0] nesting_depth;
    logic               message_done;
  } rsd_out_t;

  // parser to stack
  typedef struct packed {
    logic clear;
    logic push;
    logic finish;
  } rsd_stk_ctl_t;

  // stack to parser
  typedef struct packed {
    logic [DEPTH_W-1:0] level;
    logic               full;
    logic               fin_done;
  } rsd_stk_sts_t;

endpackage

// ===== rtl/rsd_in_reg.sv =====
// ----------------------------------------------------------------------------
// rsd_in_reg
// Input register stage: holds one beat until the parser consumes it.
// ----------------------------------------------------------------------------
module rsd_in_reg
  import rsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  rsd_in_t in_data,
  input  logic    take,
  output logic    item_vld,
  output rsd_in_t item
);

  logic    vld_r;
  logic    vld_nxt;
  rsd_in_t item_r;
  logic    load;

  assign load     = in_valid && (!vld_r || take);
  assign in_stall = vld_r && !take;
  assign vld_nxt  = load ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> vld_r)
    else $error("input stage consumed with no beat held");

endmodule

// ===== rtl/rsd_stack.sv =====
// ----------------------------------------------------------------------------
// rsd_stack
// Stack of remaining element counts for open arrays, with the nesting level
// and a close, all at once, of every array that a finished element fills.
// ----------------------------------------------------------------------------
module rsd_stack
  import rsd_pkg::*;
#(
  parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rsd_stk_ctl_t            ctl,
  input  logic [LENGTH_WIDTH-1:0] push_val,
  output rsd_stk_sts_t            sts
);

  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [LENGTH_WIDTH-1:0] pend_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0]    last_r;
  logic [DEPTH_W-1:0]      level_r;
  logic [DEPTH_W-1:0]      level_nxt;
  logic [MAX_DEPTH-1:0]    open_mask;
  logic                    found;
  logic [IW-1:0]           idx;
  logic [LENGTH_WIDTH-1:0] pend_sel;
  logic [IW-1:0]           push_idx;

  // open entries that still have more than one element to go
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      open_mask[i] = (DEPTH_W'(i) < level_r) && !last_r[i];
      if (open_mask[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

  assign pend_sel = pend_r[idx];
  assign push_idx = level_r[IW-1:0];

  always_comb begin
    level_nxt = level_r;
    if (ctl.clear) begin
      level_nxt = '0;
    end else if (ctl.push) begin
      level_nxt = level_r + DEPTH_W'(1);
    end else if (ctl.finish) begin
      level_nxt = found ? (DEPTH_W'(idx) + DEPTH_W'(1)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear) begin
      if (ctl.push) begin
        pend_r[push_idx] <= push_val;
        last_r[push_idx] <= (push_val == LENGTH_WIDTH'(1));
      end else if (ctl.finish && found) begin
        pend_r[idx] <= pend_sel - LENGTH_WIDTH'(1);
        last_r[idx] <= (pend_sel == LENGTH_WIDTH'(2));
      end
    end
  end

  assign sts.level    = level_r;
  assign sts.full     = (level_r >= DEPTH_W'(MAX_DEPTH));
  assign sts.fin_done = !found;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting level beyond stack depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !sts.full && !ctl.finish)
    else $error("push into a full stack or together with a close");

endmodule

// ===== rtl/rsd_parser.sv =====
// ----------------------------------------------------------------------------
// rsd_parser
// Byte parser: phase, type, sign, number accumulator and bulk counter, and
// the event produced by each byte.
// ----------------------------------------------------------------------------
module rsd_parser
  import rsd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  rsd_in_t                 item,
  input  rsd_stk_sts_t            sts,
  output rsd_stk_ctl_t            ctl,
  output logic [LENGTH_WIDTH-1:0] push_val,
  output logic                    res_vld,
  output rsd_out_t                res
);

  localparam logic [63:0] LEN_LIM  = (64'd1 << LENGTH_WIDTH) - 64'd1;
  localparam logic [63:0] LEN_DIV  = LEN_LIM / 64'd10;
  localparam logic [63:0] LEN_MODW = LEN_LIM % 64'd10;
  localparam logic [3:0]  LEN_MOD  = LEN_MODW[3:0];

  logic [3:0]              phase_r, phase_nxt;
  logic [2:0]              type_r, type_nxt;
  logic                    neg_r, neg_nxt;
  logic [63:0]             acc_r, acc_nxt;
  logic [LENGTH_WIDTH-1:0] rem_r, rem_nxt;

  logic [7:0]         b;
  logic [3:0]         ph;
  logic [DEPTH_W-1:0] lvl;
  logic               digit;
  logic [7:0]         dsub;
  logic [3:0]         dval;
  logic [63:0]        lim_div;
  logic [3:0]         lim_mod;
  logic               add_ok;
  logic [63:0]        acc10;
  logic [LENGTH_WIDTH-1:0] rem_dec;
  logic               fail;
  logic               vld_c;
  rsd_stk_ctl_t       ctl_c;

  assign b     = item.data_byte;
  assign digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dsub  = b - CH_ZERO;
  assign dval  = dsub[3:0];

  // overflow check and next accumulator value
  always_comb begin
    if (type_r == TY_INT) begin
      lim_div = INT_DIV;
      lim_mod = neg_r ? INT_MOD_NEG : INT_MOD_POS;
    end else begin
      lim_div = LEN_DIV;
      lim_mod = LEN_MOD;
    end
  end

  assign add_ok  = !((acc_r > lim_div) || ((acc_r == lim_div) && (dval > lim_mod)));
  assign acc10   = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, dval};
  assign rem_dec = rem_r - LENGTH_WIDTH'(1);
  assign push_val = acc_r[LENGTH_WIDTH-1:0];

  always_comb begin
    ph        = item.start_of_message ? PH_TYPE : phase_r;
    lvl       = item.start_of_message ? '0 : sts.level;
    phase_nxt = ph;
    type_nxt  = type_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    fail      = 1'b0;
    vld_c     = 1'b0;
    ctl_c     = '0;
    ctl_c.clear = item.start_of_message;
    res               = '0;
    res.nesting_depth = lvl;

    unique case (ph)
      PH_ERR: begin
      end
      PH_TYPE: begin
        neg_nxt = 1'b0;
        acc_nxt = '0;
        case (b)
          CH_PLUS: begin
            type_nxt  = TY_SIMPLE;
            phase_nxt = PH_LINE;
          end
          CH_MINUS: begin
            type_nxt  = TY_ERROR;
            phase_nxt = PH_LINE;
          end
          CH_COLON: begin
            type_nxt  = TY_INT;
            phase_nxt = PH_NUM_FIRST;
          end
          CH_DOLLAR: begin
            type_nxt  = TY_BULK;
            phase_nxt = PH_NUM_FIRST;
          end
          CH_STAR: begin
            type_nxt  = TY_ARRAY;
            phase_nxt = PH_NUM_FIRST;
          end
          default: fail = 1'b1;
        endcase
      end
      PH_LINE: begin
        if (b == CH_CR) begin
          phase_nxt = PH_LINE_LF;
        end else begin
          vld_c            = 1'b1;
          res.event_res    = (type_r == TY_ERROR) ? EV_ERROR_BYTE : EV_SIMPLE_BYTE;
          res.payload_byte = b;
        end
      end
      PH_LINE_LF: begin
        if (b != CH_LF) begin
          fail = 1'b1;
        end else begin
          ctl_c.finish     = 1'b1;
          phase_nxt        = PH_TYPE;
          vld_c            = 1'b1;
          res.event_res    = (type_r == TY_ERROR) ? EV_ERROR_END : EV_SIMPLE_END;
          res.message_done = sts.fin_done;
        end
      end
      PH_NUM_FIRST: begin
        if (b == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_NUM_SIGN;
        end else if (!digit || !add_ok) begin
          fail = 1'b1;
        end else begin
          acc_nxt   = acc10;
          phase_nxt = PH_NUM;
        end
      end
      PH_NUM_SIGN: begin
        if (!digit || !add_ok) begin
          fail = 1'b1;
        end else begin
          acc_nxt   = acc10;
          phase_nxt = PH_NUM;
        end
      end
      PH_NUM: begin
        if (b == CH_CR) begin
          phase_nxt = PH_NUM_LF;
        end else if (!digit || !add_ok) begin
          fail = 1'b1;
        end else begin
          acc_nxt = acc10;
        end
      end
      PH_NUM_LF: begin
        if (b != CH_LF) begin
          fail = 1'b1;
        end else if (type_r == TY_INT) begin
          ctl_c.finish     = 1'b1;
          phase_nxt        = PH_TYPE;
          vld_c            = 1'b1;
          res.event_res    = EV_INTEGER;
          res.value        = neg_r ? $signed(64'd0 - acc_r) : $signed(acc_r);
          res.message_done = sts.fin_done;
        end else if (neg_r) begin
          if (acc_r != 64'd1) begin
            fail = 1'b1;
          end else begin
            ctl_c.finish     = 1'b1;
            phase_nxt        = PH_TYPE;
            vld_c            = 1'b1;
            res.event_res    = (type_r == TY_BULK) ? EV_NULL_BULK : EV_NULL_ARRAY;
            res.value        = -64'sd1;
            res.message_done = sts.fin_done;
          end
        end else if (type_r == TY_BULK) begin
          rem_nxt       = acc_r[LENGTH_WIDTH-1:0];
          phase_nxt     = (acc_r != 64'd0) ? PH_BULK : PH_BULK_CR;
          vld_c         = 1'b1;
          res.event_res = EV_BULK_HDR;
          res.value     = $signed(acc_r);
        end else if (acc_r == 64'd0) begin
          ctl_c.finish     = 1'b1;
          phase_nxt        = PH_TYPE;
          vld_c            = 1'b1;
          res.event_res    = EV_ARRAY_HDR;
          res.message_done = sts.fin_done;
        end else if (sts.full) begin
          fail = 1'b1;
        end else begin
          ctl_c.push    = 1'b1;
          phase_nxt     = PH_TYPE;
          vld_c         = 1'b1;
          res.event_res = EV_ARRAY_HDR;
          res.value     = $signed(acc_r);
        end
      end
      PH_BULK: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_BULK_CR;
        end
        vld_c            = 1'b1;
        res.event_res    = EV_BULK_BYTE;
        res.payload_byte = b;
      end
      PH_BULK_CR: begin
        if (b != CH_CR) begin
          fail = 1'b1;
        end else begin
          phase_nxt = PH_BULK_LF;
        end
      end
      PH_BULK_LF: begin
        if (b != CH_LF) begin
          fail = 1'b1;
        end else begin
          ctl_c.finish     = 1'b1;
          phase_nxt        = PH_TYPE;
          vld_c            = 1'b1;
          res.event_res    = EV_BULK_END;
          res.message_done = sts.fin_done;
        end
      end
      default: fail = 1'b1;
    endcase

    // protocol error overrides everything else
    if (fail) begin
      phase_nxt         = PH_ERR;
      ctl_c.push        = 1'b0;
      ctl_c.finish      = 1'b0;
      vld_c             = 1'b1;
      res               = '0;
      res.event_res     = EV_PROTO_ERR;
      res.payload_byte  = b;
      res.nesting_depth = lvl;
    end
  end

  assign ctl     = fire ? ctl_c : '0;
  assign res_vld = fire && vld_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= TY_SIMPLE;
      neg_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.start_of_message && (phase_r == PH_ERR) |-> !res_vld)
    else $error("event produced while holding a protocol error");

  a_err_enters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && (res.event_res == EV_PROTO_ERR) |=> (phase_r == PH_ERR))
    else $error("protocol error did not enter the hold phase");

endmodule

// ===== rtl/resp_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// resp_stream_decoder_unit
// Byte-serial decoder for serialized key-value protocol messages.
//
// Usage:
//   in channel  : one message byte per beat, with a start-of-message flag
//                 that clears all parser state before that byte.
//   out channel : zero or one parse event per input byte (type, value,
//                 content byte, nesting depth, message-done flag).
//   path        : an accepted byte's event passes the input register, then the
//                 result register, before it shows on out_valid.
//   throughput  : one byte per cycle while out_stall holds no waiting event;
//                 the parser update (times-ten accumulate with overflow
//                 compare, and the array stack close) runs as the byte is taken.
//   reset       : rst_n (synchronous) empties both registers and returns the
//                 parser to expect a type byte at nesting level zero.
//   stall       : while out_stall holds a waiting event, the byte in the
//                 input register waits and in_stall rises; bytes that make
//                 no event still wait behind the held result.
//   errors      : a protocol error event is followed by silence until a
//                 beat with start_of_message set.
// ----------------------------------------------------------------------------
module resp_stream_decoder_unit
  import rsd_pkg::*;
#(
  parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rsd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rsd_out_t out_data
);

  logic                    item_vld;
  rsd_in_t                 item;
  logic                    adv;
  rsd_stk_ctl_t            stk_ctl;
  rsd_stk_sts_t            stk_sts;
  logic [LENGTH_WIDTH-1:0] push_val;
  logic                    res_vld;
  rsd_out_t                res;
  logic                    out_vld_r;
  rsd_out_t                out_r;

  assign adv = item_vld && (!out_vld_r || !out_stall);

  rsd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  rsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (adv),
    .item     (item),
    .sts      (stk_sts),
    .ctl      (stk_ctl),
    .push_val (push_val),
    .res_vld  (res_vld),
    .res      (res)
  );

  rsd_stack #(
    .MAX_DEPTH    (MAX_DEPTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stk_ctl),
    .push_val (push_val),
    .sts      (stk_sts)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_err_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.event_res == EV_PROTO_ERR) |-> !out_r.message_done)
    else $error("protocol error beat flagged as message done");

endmodule
